### rtl/npc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg: shared constants for the nearest palette color search
// Field widths, command codes and the distance range used by the block
// and its channel interfaces.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int COLOR_W    = 8;    // one color component
    localparam int INDEX_W    = 8;    // entry_index / nearest_index
    localparam int ADDR_SPACE = 256;  // entries reachable through an 8-bit index
    localparam int SQ_W       = 2 * COLOR_W;
    localparam int DIST_W     = 18;   // 3 * 255^2 = 195075 fits
    localparam int RGB_W      = 3 * COLOR_W;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [SQ_W-1:0]    sq_t;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    // larger than any real distance, so the first entry always wins
    localparam dist_t DIST_INIT = '1;
    localparam dist_t DIST_MAX  = DIST_W'(3 * 255 * 255);

endpackage

`default_nettype wire

### rtl/npc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npc_if: valid/ready channels of the nearest palette color search
// npc_req_if carries write and search commands, npc_rsp_if the found index.
// ----------------------------------------------------------------------------
interface npc_req_if;

    logic              valid;
    logic              ready;
    npc_pkg::cmd_t     command;
    npc_pkg::index_t   entry_index;
    npc_pkg::color_t   red;
    npc_pkg::color_t   green;
    npc_pkg::color_t   blue;

    modport source (output valid, command, entry_index, red, green, blue, input ready);
    modport sink   (input valid, command, entry_index, red, green, blue, output ready);

endinterface

interface npc_rsp_if;

    logic              valid;
    logic              ready;
    npc_pkg::index_t   nearest_index;

    modport source (output valid, nearest_index, input ready);
    modport sink   (input valid, nearest_index, output ready);

endinterface

`default_nettype wire

### rtl/nearest_palette_color.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color: nearest palette entry by squared RGB distance
// Palette RAM with a one-entry-per-cycle search walk.
// ----------------------------------------------------------------------------
// The block keeps a palette of min(PALETTE_ENTRIES, 256) colors in a
// single-port-write, synchronous-read RAM, all entries reading as black after
// reset (a per-entry valid bit masks entries never written). A write
// transaction (command CMD_WRITE) stores one entry and returns nothing; an
// index at or past the palette depth is dropped. A search transaction
// (command CMD_SEARCH) walks every entry, one RAM read per cycle, and returns
// one result transaction holding the lowest index at the smallest
// dr^2 + dg^2 + db^2. After acceptance a search issues every address on the
// RAM read port, then lets the read, square and compare stages drain, then
// loads the result register. The next transaction can be accepted in the
// same cycle that the result is first offered. Commands are taken one at a
// time; a write or a new search may be accepted while an earlier result
// still waits in the output register.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    npc_req_if.sink    req,
    npc_rsp_if.source  rsp
);

    // only the first 256 entries can be addressed by an 8-bit index
    localparam int DEPTH = (PALETTE_ENTRIES < npc_pkg::ADDR_SPACE) ?
                           PALETTE_ENTRIES : npc_pkg::ADDR_SPACE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic [AW-1:0] addr_t;
    localparam addr_t LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [3:0]
    {
        ST_IDLE  = 4'b0001,   // accepting transactions
        ST_SCAN  = 4'b0010,   // issuing RAM reads
        ST_DRAIN = 4'b0100,   // read/square/compare pipeline emptying
        ST_DONE  = 4'b1000    // best index ready for the output register
    } state_t;

    state_t state_reg, state_next;

    // ---------------------------------------------------------------- input
    logic req_fire;
    logic wr_fire;
    logic search_fire;
    logic wr_in_range;

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_fire    = req.valid & req.ready;
    assign wr_fire     = req_fire & (req.command == npc_pkg::CMD_WRITE);
    assign search_fire = req_fire & (req.command == npc_pkg::CMD_SEARCH);
    assign wr_in_range = ({1'b0, req.entry_index} < 9'(DEPTH));

    // query color held for the whole walk
    npc_pkg::color_t q_red_reg, q_green_reg, q_blue_reg;

    always_ff @(posedge clk)
    begin
        if (search_fire)
        begin
            q_red_reg   <= req.red;
            q_green_reg <= req.green;
            q_blue_reg  <= req.blue;
        end
    end

    // ---------------------------------------------------------- palette RAM
    // Writes happen only in IDLE and reads only matter during SCAN, so the
    // two never touch the same entry in one cycle.
    logic [npc_pkg::RGB_W-1:0] pal_mem [DEPTH];
    logic [npc_pkg::RGB_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]          pal_vld_reg;
    logic                      rd_ok_reg;
    addr_t                     wr_addr;
    addr_t                     scan_cnt_reg, scan_cnt_next;

    assign wr_addr = req.entry_index[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_fire && wr_in_range)
        begin
            pal_mem[wr_addr] <= {req.red, req.green, req.blue};
        end
        rd_data_reg <= pal_mem[scan_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_vld_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_fire && wr_in_range)
            begin
                pal_vld_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= pal_vld_reg[scan_cnt_reg];
        end
    end

    // ------------------------------------------------------------- pipeline
    // s1: RAM output; s2: squared differences; compare updates best.
    logic  s1_vld_reg, s1_last_reg;
    addr_t s1_idx_reg;
    logic  s2_vld_reg, s2_last_reg;
    addr_t s2_idx_reg;
    npc_pkg::sq_t sq_r_reg, sq_g_reg, sq_b_reg;

    logic                      issue;
    logic                      issue_last;
    logic [npc_pkg::RGB_W-1:0] ent_rgb;
    npc_pkg::color_t           ent_r, ent_g, ent_b;
    npc_pkg::color_t           dr, dg, db;

    assign issue      = (state_reg == ST_SCAN);
    assign issue_last = issue & (scan_cnt_reg == LAST_ADDR);

    // never-written entries read as black
    assign ent_rgb = rd_ok_reg ? rd_data_reg : '0;
    assign ent_r   = ent_rgb[3*npc_pkg::COLOR_W-1 -: npc_pkg::COLOR_W];
    assign ent_g   = ent_rgb[2*npc_pkg::COLOR_W-1 -: npc_pkg::COLOR_W];
    assign ent_b   = ent_rgb[npc_pkg::COLOR_W-1   -: npc_pkg::COLOR_W];

    assign dr = (q_red_reg   >= ent_r) ? (q_red_reg   - ent_r) : (ent_r - q_red_reg);
    assign dg = (q_green_reg >= ent_g) ? (q_green_reg - ent_g) : (ent_g - q_green_reg);
    assign db = (q_blue_reg  >= ent_b) ? (q_blue_reg  - ent_b) : (ent_b - q_blue_reg);

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= scan_cnt_reg;
        s2_idx_reg <= s1_idx_reg;
        sq_r_reg   <= npc_pkg::SQ_W'(dr) * npc_pkg::SQ_W'(dr);
        sq_g_reg   <= npc_pkg::SQ_W'(dg) * npc_pkg::SQ_W'(dg);
        sq_b_reg   <= npc_pkg::SQ_W'(db) * npc_pkg::SQ_W'(db);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= issue;
            s1_last_reg <= issue_last;
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // -------------------------------------------------------------- compare
    npc_pkg::dist_t walk_dist;
    npc_pkg::dist_t best_dist_reg;
    addr_t          best_idx_reg;
    logic           take;

    assign walk_dist = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                     + npc_pkg::DIST_W'(sq_b_reg);
    // strict less-than while walking upward keeps the lowest index on a tie
    assign take = s2_vld_reg & (walk_dist < best_dist_reg);

    always_ff @(posedge clk)
    begin
        if (search_fire)
        begin
            best_dist_reg <= npc_pkg::DIST_INIT;
            best_idx_reg  <= '0;
        end
        else if (take)
        begin
            best_dist_reg <= walk_dist;
            best_idx_reg  <= s2_idx_reg;
        end
    end

    // -------------------------------------------------------- state machine
    logic rsp_free;

    assign rsp_free = ~rsp.valid | rsp.ready;

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (search_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (issue_last)
                begin
                    scan_cnt_next = '0;
                    state_next    = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                scan_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    // ------------------------------------------------------ result register
    logic            rsp_vld_reg;
    npc_pkg::index_t rsp_idx_reg;
    logic            rsp_load;

    assign rsp_load = (state_reg == ST_DONE) & rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_idx_reg <= npc_pkg::INDEX_W'(best_idx_reg);
        end
    end

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.nearest_index = rsp_idx_reg;

    // ----------------------------------------------------------- assertions
    // an accepted search always starts the walk
    a_search_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        search_fire |=> (state_reg == ST_SCAN))
        else $error("search transaction did not start the palette walk");

    // the pipeline is empty once the best index is final
    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("compare pipeline still busy when result is taken");

    // at least one entry was compared, so the best distance is a real one
    a_best_dist_real: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (best_dist_reg <= npc_pkg::DIST_MAX))
        else $error("no palette entry was compared during the walk");

    // the walk pipeline never runs outside a search
    a_pipe_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("walk pipeline active while idle");

endmodule

`default_nettype wire
